// File: hw/rtl/nrm_pkg.sv
// Package with the shared constants and types of the L2 vector normalizer.
`default_nettype none
package nrm_pkg;
  localparam int unsigned VECTOR_LEN_DEF = 256;
  localparam int unsigned LANES_DEF      = 4;
  localparam int unsigned ELEM_W         = 16;
  localparam int unsigned SQ_W           = 31;
  localparam int unsigned NUM_W          = 44;
  localparam int unsigned FRAC_SHIFT     = 28;
  localparam int unsigned RAD_SHIFT      = 24;
  localparam int unsigned QBITS          = 17;
  localparam logic [QBITS-1:0] QPOS_MAX  = 17'd32767;
  localparam logic [QBITS-1:0] QNEG_MAX  = 17'd32768;

  typedef struct packed {
    logic init;
    logic step;
  } nrm_div_ctrl_t;

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_SUMW = 6'b000010,
    ST_SQST = 6'b000100,
    ST_ROOT = 6'b001000,
    ST_READ = 6'b010000,
    ST_DIV  = 6'b100000
  } nrm_state_e;
endpackage
`default_nettype wire

// File: hw/rtl/nrm_sqrt.sv
// Iterative integer square root, one root bit per cycle.
`default_nettype none
module nrm_sqrt import nrm_pkg::*; #(
  parameter int unsigned SUM_W  = 39,
  parameter int unsigned ROOT_W = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SUM_W-1:0]  sum_i,
  output logic                   busy_o,
  output logic [ROOT_W-1:0]      root_o
);
  localparam int unsigned RAD_W = 2 * ROOT_W;
  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [ROOT_W+1:0] rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ROOT_W+3:0] rem_sh, trial;

  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = rem_sh - {2'b00, root_q, 2'b01};

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      rad_d  = RAD_W'({sum_i, {RAD_SHIFT{1'b0}}});
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(ROOT_W);
    end else if (cnt_q != '0) begin
      rad_d = {rad_q[RAD_W-3:0], 2'b00};
      cnt_d = cnt_q - 1'b1;
      if (!trial[ROOT_W+3]) begin
        rem_d  = trial[ROOT_W+1:0];
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[ROOT_W+1:0];
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = (cnt_q != '0);
  assign root_o = root_q;
endmodule
`default_nettype wire

// File: hw/rtl/nrm_lane.sv
// One lane: element memory, squarer and a bit-serial divider for the scaling.
`default_nettype none
module nrm_lane import nrm_pkg::*; #(
  parameter int unsigned SLOTS  = 64,
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned ROOT_W = 32
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [ELEM_W-1:0] wr_data_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  input  wire nrm_div_ctrl_t     ctrl_i,
  input  wire logic [ROOT_W-1:0] root_i,
  output logic [SQ_W-1:0]        sq_o,
  output logic [ELEM_W-1:0]      res_o
);
  localparam int unsigned D_W = ROOT_W + 1;

  logic [ELEM_W-1:0] mem [SLOTS];
  logic [ELEM_W-1:0] rd_q;
  logic [SQ_W-1:0]   sq_q;
  logic [D_W-1:0]    rem_q;
  logic [QBITS-1:0]  lo_q, q_q;
  logic              neg_q, sat_q;
  logic [ELEM_W-1:0] mag;
  logic [NUM_W-1:0]  num;
  logic [D_W-1:0]    div;
  logic [D_W:0]      trial;
  logic              fits;
  logic signed [2*ELEM_W-1:0] prod;

  assign prod = $signed(wr_data_i) * $signed(wr_data_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
      sq_q           <= prod[SQ_W-1:0];
    end
    rd_q <= mem[rd_addr_i];
  end

  assign mag   = rd_q[ELEM_W-1] ? (~rd_q + 1'b1) : rd_q;
  assign num   = {mag, {FRAC_SHIFT{1'b0}}} + NUM_W'(root_i);
  assign div   = {root_i, 1'b0};
  assign trial = {rem_q, lo_q[QBITS-1]};
  assign fits  = (trial >= {1'b0, div});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      neg_q <= rd_q[ELEM_W-1];
      rem_q <= D_W'(num[NUM_W-1:QBITS]);
      sat_q <= (D_W'(num[NUM_W-1:QBITS]) >= div);
      lo_q  <= num[QBITS-1:0];
      q_q   <= '0;
    end else if (ctrl_i.step) begin
      lo_q  <= {lo_q[QBITS-2:0], 1'b0};
      q_q   <= {q_q[QBITS-2:0], fits};
      rem_q <= fits ? D_W'(trial - {1'b0, div}) : trial[D_W-1:0];
    end
  end

  always_comb begin
    if (neg_q) begin
      if (sat_q || q_q > QNEG_MAX) res_o = 16'h8000;
      else                         res_o = ~q_q[ELEM_W-1:0] + 1'b1;
    end else begin
      if (sat_q || q_q > QPOS_MAX) res_o = 16'h7fff;
      else                         res_o = q_q[ELEM_W-1:0];
    end
  end

  assign sq_o = sq_q;
endmodule
`default_nettype wire

// File: hw/rtl/nrm_merge.sv
// Merging stage: adds the lane squares into the running sum of squares.
`default_nettype none
module nrm_merge import nrm_pkg::*; #(
  parameter int unsigned LANES = 4,
  parameter int unsigned SUM_W = 39
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            add_i,
  input  wire logic            clear_i,
  input  wire logic [SQ_W-1:0] sq_i [LANES],
  output logic [SUM_W-1:0]     sum_o
);
  logic [SUM_W-1:0] sum_q, sum_d, lane_sum;

  always_comb begin
    lane_sum = '0;
    for (int l = 0; l < LANES; l++) begin
      lane_sum = lane_sum + SUM_W'(sq_i[l]);
    end
    sum_d = sum_q;
    if (clear_i)    sum_d = '0;
    else if (add_i) sum_d = sum_q + lane_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;
endmodule
`default_nettype wire

// File: hw/rtl/l2_vector_normalizer.sv
// Load: one word per cycle while the block is in its load state. After the closing word the
// square root of the sum of squares is computed; then each result word takes one memory read
// and the 17-step bit-serial dividers that all lanes run side by side.
// No new word is taken until the last result word sits in the output register.
// Reset is asynchronous, active low; it clears control, sum and count, not the memories.
`default_nettype none
module l2_vector_normalizer import nrm_pkg::*; #(
  parameter int unsigned VECTOR_LEN = VECTOR_LEN_DEF,
  parameter int unsigned LANES      = LANES_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // Fields from bit 0 up: elem_a, elem_b, elem_c, elem_d (one per lane).
  input  wire logic [LANES*ELEM_W-1:0] s_axis_tdata_i,
  input  wire logic                    s_axis_tlast_i,
  output logic                         m_axis_tvalid_o,
  input  wire logic                    m_axis_tready_i,
  // Fields from bit 0 up: norm_a, norm_b, norm_c, norm_d (one per lane).
  output logic [LANES*ELEM_W-1:0]      m_axis_tdata_o,
  output logic                         m_axis_tlast_o,
  // Fields from bit 0 up: zero_norm.
  output logic                         m_axis_tuser_o
);
  localparam int unsigned SLOTS  = VECTOR_LEN / LANES;
  localparam int unsigned ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W  = ADDR_W + 1;
  localparam int unsigned SUM_W  = SQ_W + $clog2(VECTOR_LEN);
  localparam int unsigned ROOT_W = (SUM_W + RAD_SHIFT + 1) / 2;
  localparam int unsigned DC_W   = $clog2(QBITS + 1);

  nrm_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] row_q, row_d;
  logic [DC_W-1:0]   dc_q, dc_d;
  logic              sqv_q;
  logic              out_valid_q, out_valid_d;
  logic [LANES*ELEM_W-1:0] out_data_q;
  logic              out_last_q, out_user_q;
  logic              in_fire, wr_en, load_out, last_row, clear, zero;
  logic [SQ_W-1:0]   sq [LANES];
  logic [ELEM_W-1:0] res [LANES];
  logic [SUM_W-1:0]  sum;
  logic [ROOT_W-1:0] root;
  logic              sqrt_busy;
  nrm_div_ctrl_t     ctrl;
  logic [LANES*ELEM_W-1:0] res_flat;

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_en    = in_fire && (cnt_q < CNT_W'(SLOTS));
  assign last_row = ((CNT_W'(row_q) + 1'b1) == cnt_q);
  assign zero     = (sum == '0);
  assign ctrl.init = (state_q == ST_DIV) && (dc_q == '0);
  assign ctrl.step = (state_q == ST_DIV) && (dc_q != '0) && (dc_q <= DC_W'(QBITS));
  // The last division step is done; the row goes out once the output register is free.
  assign load_out = (state_q == ST_DIV) && (dc_q == DC_W'(QBITS + 1)) &&
                    (!out_valid_q || m_axis_tready_i);
  assign clear    = load_out && last_row;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    nrm_lane #(.SLOTS(SLOTS), .ADDR_W(ADDR_W), .ROOT_W(ROOT_W)) u_lane (
      .clk_i     (clk_i),
      .wr_en_i   (wr_en),
      .wr_addr_i (cnt_q[ADDR_W-1:0]),
      .wr_data_i (s_axis_tdata_i[l*ELEM_W +: ELEM_W]),
      .rd_addr_i (row_q),
      .ctrl_i    (ctrl),
      .root_i    (root),
      .sq_o      (sq[l]),
      .res_o     (res[l])
    );
    assign res_flat[l*ELEM_W +: ELEM_W] = res[l];
  end

  nrm_merge #(.LANES(LANES), .SUM_W(SUM_W)) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .add_i   (sqv_q),
    .clear_i (clear),
    .sq_i    (sq),
    .sum_o   (sum)
  );

  nrm_sqrt #(.SUM_W(SUM_W), .ROOT_W(ROOT_W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_SQST),
    .sum_i   (sum),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    row_d       = row_q;
    dc_d        = dc_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    unique case (state_q)
      ST_LOAD: begin
        if (wr_en) cnt_d = cnt_q + 1'b1;
        if (in_fire && s_axis_tlast_i) state_d = ST_SUMW;
      end
      ST_SUMW: state_d = ST_SQST;
      ST_SQST: state_d = ST_ROOT;
      ST_ROOT: begin
        if (!sqrt_busy) begin
          row_d   = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        dc_d    = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (dc_q != DC_W'(QBITS + 1)) begin
          dc_d = dc_q + 1'b1;
        end else if (load_out) begin
          out_valid_d = 1'b1;
          if (last_row) begin
            cnt_d   = '0;
            state_d = ST_LOAD;
          end else begin
            row_d   = row_q + 1'b1;
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      row_q       <= '0;
      dc_q        <= '0;
      sqv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      dc_q        <= dc_d;
      sqv_q       <= wr_en;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= zero ? '0 : res_flat;
      out_last_q <= last_row;
      out_user_q <= zero;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_user_q;
endmodule
`default_nettype wire
